### hdl/sorted_key_dedup_counter_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sorted key dedup counter
// Concurrent assertion wrappers that compile away when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef SORTED_KEY_DEDUP_COUNTER_CORE_DEFINES_SVH
`define SORTED_KEY_DEDUP_COUNTER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising clock edge, held off while reset is asserted.
`define SKDC_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SKDC_ASSERT_ALWAYS(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) prop) else $error(msg);

`else

`define SKDC_ASSERT(lbl, ck, rn, prop, msg)

`define SKDC_ASSERT_ALWAYS(lbl, ck, prop, msg)

`endif

`endif

### hdl/skdc_pkg.sv
// ---------------------------------------------------------------------------
// Sorted key dedup counter package
// Field widths, codes and defaults shared by the interfaces and the core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package skdc_pkg;

	localparam int CAPACITY_DEF  = 256;
	localparam int KEY_BYTES_DEF = 8;

	localparam int OP_W       = 2;
	localparam int KEY_W      = 64;
	localparam int POS_W      = 8;
	localparam int FIRST_W    = 8;
	localparam int MULT_W     = 9;
	localparam int COUNT_W    = 9;
	localparam int LIMIT_W    = 9;
	localparam int KB_W       = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ITEM_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES  = 1'b1;

	localparam logic [LIMIT_W-1:0] ITEM_LIMIT_RST = 9'd256;
	localparam logic [KB_W-1:0]    KEY_BYTES_RST  = 4'd8;

endpackage

`default_nettype wire

### hdl/skdc_ifs.sv
// ---------------------------------------------------------------------------
// Sorted key dedup counter channels
// Valid/ready channels for command words and result words.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface skdc_cmd_if;
	import skdc_pkg::*;

	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  op;
	logic [KEY_W-1:0] key;

	modport source (output valid, op, key, input ready);
	modport sink (input valid, op, key, output ready);
endinterface

interface skdc_res_if;
	import skdc_pkg::*;

	logic               valid;
	logic               ready;
	logic               found;
	logic [POS_W-1:0]   position;
	logic [FIRST_W-1:0] first_seen;
	logic [MULT_W-1:0]  multiplicity;
	logic [COUNT_W-1:0] class_count;
	logic [COUNT_W-1:0] items_seen;
	logic               status;

	modport source (output valid, found, position, first_seen, multiplicity, class_count,
		items_seen, status, input ready);
	modport sink (input valid, found, position, first_seen, multiplicity, class_count,
		items_seen, status, output ready);
endinterface

`default_nettype wire

### hdl/skdc_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### hdl/sorted_key_dedup_counter_core.sv
// ---------------------------------------------------------------------------
// Sorted key dedup counter core
// Sorted table of distinct keys with multiplicities: insert, lookup, clear.
// ---------------------------------------------------------------------------
// The block takes one command word at a time and answers each with one result
// word. Entries live in a single RAM with registered read data; every command
// but a clear binary-searches it, each probe passing through a search and a
// compare state, then checks the entry at the lower bound, and on an insert
// miss moves every higher entry up by one, one entry per cycle through the
// RAM's read and write ports. No clearing pass runs after reset.
// A finished result waits in an output register, and the next command word
// is accepted in the cycle after the previous result has been handed to that
// register.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_key_dedup_counter_core_defines.svh"

module sorted_key_dedup_counter_core #(
	parameter int CAPACITY  = skdc_pkg::CAPACITY_DEF,
	parameter int KEY_BYTES = skdc_pkg::KEY_BYTES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [skdc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [skdc_pkg::CFG_DATA_W-1:0]  cfg_data,
	skdc_cmd_if.sink                              cmd,
	skdc_res_if.source                            res
);
	import skdc_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int KW = 8 * KEY_BYTES;
	localparam int EW = KW + MULT_W + FIRST_W;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_SRCH  = 8'b0000_0010,
		S_CMP   = 8'b0000_0100,
		S_CHK   = 8'b0000_1000,
		S_DEC   = 8'b0001_0000,
		S_SHIFT = 8'b0010_0000,
		S_INS   = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic               found;
		logic [POS_W-1:0]   position;
		logic [FIRST_W-1:0] first_seen;
		logic [MULT_W-1:0]  multiplicity;
		logic               status;
	} result_t;

	state_t             state_q;
	logic [OP_W-1:0]    op_q;
	logic [KW-1:0]      k_q;
	logic [KW-1:0]      m_q;
	logic [CW-1:0]      lo_q;
	logic [CW-1:0]      hi_q;
	logic               found_q;
	logic [KW-1:0]      ekey_q;
	logic [MULT_W-1:0]  emult_q;
	logic [FIRST_W-1:0] efirst_q;
	logic [AW-1:0]      w_q;
	logic [CW-1:0]      distinct_q;
	logic [CW-1:0]      item_q;
	logic [LIMIT_W-1:0] item_limit_q;
	logic [KB_W-1:0]    key_bytes_q;
	result_t            res_q;
	result_t            out_q;
	logic [COUNT_W-1:0] out_count_q;
	logic [COUNT_W-1:0] out_items_q;
	logic               ov_q;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [EW-1:0]      ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [EW-1:0]      ram_rdata;

	logic [KB_W-1:0]    kb_eff;
	logic [KW-1:0]      key_mask;
	logic [CW:0]        mid_sum;
	logic [CW-1:0]      mid;
	logic [KW-1:0]      rd_key_raw;
	logic [KW-1:0]      rd_key;
	logic [MULT_W-1:0]  rd_mult;
	logic [FIRST_W-1:0] rd_first;
	logic               full;
	logic               do_ins;
	logic               shift_more;
	logic [AW-1:0]      wm1;
	logic [AW-1:0]      wm2;
	logic [EW-1:0]      new_entry;
	logic               out_free;

	skdc_ram #(
		.WIDTH (EW),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Compare width is clamped to one byte at least and to the stored width at most.
	always_comb begin
		if (key_bytes_q == '0) begin
			kb_eff = KB_W'(1);
		end else if (key_bytes_q > KB_W'(KEY_BYTES)) begin
			kb_eff = KB_W'(KEY_BYTES);
		end else begin
			kb_eff = key_bytes_q;
		end
	end

	always_comb begin
		for (int b = 0; b < KEY_BYTES; b++) begin
			key_mask[KW-1-8*b -: 8] = (KB_W'(b) < kb_eff) ? 8'hFF : 8'h00;
		end
	end

	assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid        = mid_sum[CW:1];
	assign rd_key_raw = ram_rdata[EW-1 -: KW];
	assign rd_key     = rd_key_raw & m_q;
	assign rd_mult    = ram_rdata[FIRST_W +: MULT_W];
	assign rd_first   = ram_rdata[FIRST_W-1:0];
	assign full       = (32'(item_q) >= 32'(item_limit_q)) || (32'(item_q) >= 32'(CAPACITY));
	assign do_ins     = (op_q == OP_INSERT) && !full;
	assign wm1        = w_q - 1'b1;
	assign wm2        = wm1 - 1'b1;
	assign shift_more = 32'(w_q) > (32'(lo_q) + 32'd1);
	assign new_entry  = {k_q, MULT_W'(1), FIRST_W'(item_q)};
	assign out_free   = !ov_q || res.ready;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = w_q;
		ram_wdata = new_entry;
		ram_raddr = AW'(mid);
		unique case (state_q)
			S_SRCH: begin
				if (lo_q >= hi_q) begin
					ram_raddr = AW'(lo_q);
				end
			end
			S_DEC: begin
				if (do_ins && found_q) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(lo_q);
					ram_wdata = {ekey_q, MULT_W'(emult_q + 1'b1), efirst_q};
				end else if (do_ins && (distinct_q > lo_q)) begin
					ram_raddr = AW'(distinct_q - 1'b1);
				end else if (do_ins) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(lo_q);
				end
			end
			S_SHIFT: begin
				// Entry read last cycle moves up one slot while the next lower one is read.
				ram_we    = 1'b1;
				ram_waddr = w_q;
				ram_wdata = ram_rdata;
				ram_raddr = wm2;
			end
			S_INS: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(lo_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			distinct_q   <= '0;
			item_q       <= '0;
			item_limit_q <= ITEM_LIMIT_RST;
			key_bytes_q  <= KEY_BYTES_RST;
			ov_q         <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ITEM_LIMIT: item_limit_q <= cfg_data[LIMIT_W-1:0];
					CFG_KEY_BYTES:  key_bytes_q  <= cfg_data[KB_W-1:0];
				endcase
			end

			if (state_q == S_DONE && out_free) begin
				ov_q <= 1'b1;
			end else if (res.ready) begin
				ov_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						op_q <= cmd.op;
						k_q  <= cmd.key[KEY_W-1 -: KW] & key_mask;
						m_q  <= key_mask;
						lo_q <= '0;
						hi_q <= distinct_q;
						if (cmd.op == OP_CLEAR) begin
							distinct_q <= '0;
							item_q     <= '0;
							res_q      <= '0;
							state_q    <= S_DONE;
						end else begin
							state_q <= S_SRCH;
						end
					end
				end
				S_SRCH: begin
					if (lo_q < hi_q) begin
						state_q <= S_CMP;
					end else if (lo_q < distinct_q) begin
						state_q <= S_CHK;
					end else begin
						found_q <= 1'b0;
						state_q <= S_DEC;
					end
				end
				S_CMP: begin
					if (rd_key < k_q) begin
						lo_q <= mid + 1'b1;
					end else begin
						hi_q <= mid;
					end
					state_q <= S_SRCH;
				end
				S_CHK: begin
					found_q  <= (rd_key == k_q);
					ekey_q   <= rd_key_raw;
					emult_q  <= rd_mult;
					efirst_q <= rd_first;
					state_q  <= S_DEC;
				end
				S_DEC: begin
					res_q.found    <= found_q;
					res_q.position <= POS_W'(lo_q);
					res_q.status   <= (op_q == OP_INSERT) && full;
					if (do_ins && found_q) begin
						res_q.first_seen   <= efirst_q;
						res_q.multiplicity <= MULT_W'(emult_q + 1'b1);
						item_q             <= item_q + 1'b1;
						state_q            <= S_DONE;
					end else if (do_ins && (distinct_q > lo_q)) begin
						w_q     <= AW'(distinct_q);
						state_q <= S_SHIFT;
					end else if (do_ins) begin
						res_q.first_seen   <= FIRST_W'(item_q);
						res_q.multiplicity <= MULT_W'(1);
						distinct_q         <= distinct_q + 1'b1;
						item_q             <= item_q + 1'b1;
						state_q            <= S_DONE;
					end else begin
						res_q.first_seen   <= found_q ? efirst_q : '0;
						res_q.multiplicity <= found_q ? emult_q : '0;
						state_q            <= S_DONE;
					end
				end
				S_SHIFT: begin
					if (shift_more) begin
						w_q <= wm1;
					end else begin
						state_q <= S_INS;
					end
				end
				S_INS: begin
					res_q.first_seen   <= FIRST_W'(item_q);
					res_q.multiplicity <= MULT_W'(1);
					distinct_q         <= distinct_q + 1'b1;
					item_q             <= item_q + 1'b1;
					state_q            <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result payload; the counters are final by the time the sequencer reaches its last state.
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_q       <= res_q;
			out_count_q <= COUNT_W'(distinct_q);
			out_items_q <= COUNT_W'(item_q);
		end
	end

	assign cmd.ready        = (state_q == S_IDLE);
	assign res.valid        = ov_q;
	assign res.found        = out_q.found;
	assign res.position     = out_q.position;
	assign res.first_seen   = out_q.first_seen;
	assign res.multiplicity = out_q.multiplicity;
	assign res.class_count  = out_count_q;
	assign res.items_seen   = out_items_q;
	assign res.status       = out_q.status;

	`SKDC_ASSERT(a_distinct_le_items, clk, arst_n, distinct_q <= item_q, "more keys than items")
	`SKDC_ASSERT(a_ram_write_state, clk, arst_n, ram_we |-> (state_q == S_DEC || state_q == S_SHIFT || state_q == S_INS), "RAM written outside update")
	`SKDC_ASSERT(a_shift_above_pos, clk, arst_n, (state_q == S_SHIFT) |-> (32'(w_q) > 32'(lo_q)), "shift writes at or below insert point")
	`SKDC_ASSERT(a_search_bounds, clk, arst_n, (state_q == S_SRCH) |-> (lo_q <= hi_q && hi_q <= distinct_q), "search bounds crossed")
	`SKDC_ASSERT(a_result_from_done, clk, arst_n, $rose(ov_q) |-> $past(state_q == S_DONE), "result word without finished item")

endmodule

`default_nettype wire

### tb/sv/sorted_key_dedup_counter_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted key dedup counter core testbench
// Drives insert, lookup and clear words through the command channel under
// several register settings. A scoreboard keeps its own sorted key table and
// checks each result word in order. Both channels idle and stall at random.
// ---------------------------------------------------------------------------

module sorted_key_dedup_counter_core_test;
	import skdc_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
	localparam int ITEMS_TARGET = 1900;
	localparam int LONG_HOLD = 600;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES = 300;

	typedef struct packed {
		logic               found;
		logic [POS_W-1:0]   position;
		logic [FIRST_W-1:0] first_seen;
		logic [MULT_W-1:0]  multiplicity;
		logic [COUNT_W-1:0] class_count;
		logic [COUNT_W-1:0] items_seen;
		logic               status;
	} answer_t;

	class dedup_scoreboard;
		logic [KEY_W-1:0]   entry_key [CAPACITY_DEF];
		logic [MULT_W-1:0]  entry_mult [CAPACITY_DEF];
		logic [FIRST_W-1:0] entry_first [CAPACITY_DEF];
		int unsigned distinct_n, counted_n;
		logic [LIMIT_W-1:0] limit_reg;
		logic [KB_W-1:0] width_reg;
		answer_t awaited_answers[$];
		int unsigned mismatches, answers_seen, hits, refusals, clears;
		int unsigned peak_distinct, peak_mult;

		function new();
			distinct_n = 0;
			counted_n = 0;
			limit_reg = ITEM_LIMIT_RST;
			width_reg = KEY_BYTES_RST;
			mismatches = 0;
			answers_seen = 0;
			hits = 0;
			refusals = 0;
			clears = 0;
			peak_distinct = 0;
			peak_mult = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_ITEM_LIMIT) begin
				limit_reg = data[LIMIT_W-1:0];
			end else begin
				width_reg = data[KB_W-1:0];
			end
		endfunction

		// Only the leading bytes count; a width of zero acts as one byte.
		function logic [KEY_W-1:0] key_mask();
			int unsigned n;
			n = width_reg;
			if (n < 1) n = 1;
			if (n > KEY_BYTES_DEF) n = KEY_BYTES_DEF;
			if (n >= 8) return {KEY_W{1'b1}};
			return ~({KEY_W{1'b1}} >> (8 * n));
		endfunction

		function int unsigned pending();
			return awaited_answers.size();
		endfunction

		function void take_command(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
			answer_t r;
			logic [KEY_W-1:0] m, k;
			int unsigned lo, hi, mid, pos, limit, i;
			bit hit, counting;
			r = '0;
			if (op == OP_CLEAR) begin
				distinct_n = 0;
				counted_n = 0;
				clears++;
				awaited_answers.push_back(r);
				return;
			end
			m = key_mask();
			k = key & m;
			limit = (limit_reg > CAPACITY_DEF) ? CAPACITY_DEF : limit_reg;
			// Lower-bound search over the keys as masked now; the table may be
			// out of order under a narrower width, and the search follows it as is.
			lo = 0;
			hi = distinct_n;
			while (lo < hi) begin
				mid = (lo + hi) / 2;
				if ((entry_key[mid] & m) < k) lo = mid + 1;
				else hi = mid;
			end
			pos = lo;
			hit = (pos < distinct_n) && ((entry_key[pos] & m) == k);
			counting = (op == OP_INSERT);
			if (counting && counted_n >= limit) begin
				r.status = 1'b1;
				counting = 0;
				refusals++;
			end
			if (counting) begin
				if (hit) begin
					entry_mult[pos]++;
				end else if (distinct_n < CAPACITY_DEF) begin
					for (i = distinct_n; i > pos; i--) begin
						entry_key[i] = entry_key[i-1];
						entry_mult[i] = entry_mult[i-1];
						entry_first[i] = entry_first[i-1];
					end
					entry_key[pos] = k;
					entry_mult[pos] = 1;
					entry_first[pos] = FIRST_W'(counted_n);
					distinct_n++;
				end
				counted_n++;
				r.first_seen = entry_first[pos];
				r.multiplicity = entry_mult[pos];
			end else if (hit) begin
				r.first_seen = entry_first[pos];
				r.multiplicity = entry_mult[pos];
			end
			if (hit) hits++;
			if (distinct_n > peak_distinct) peak_distinct = distinct_n;
			if (r.multiplicity > peak_mult) peak_mult = r.multiplicity;
			r.found = hit;
			r.position = POS_W'(pos);
			r.class_count = COUNT_W'(distinct_n);
			r.items_seen = COUNT_W'(counted_n);
			awaited_answers.push_back(r);
		endfunction

		function string show(answer_t a);
			return $sformatf("found=%0d pos=%0d first=%0d mult=%0d classes=%0d items=%0d status=%0d",
				a.found, a.position, a.first_seen, a.multiplicity, a.class_count,
				a.items_seen, a.status);
		endfunction

		function void check_answer(answer_t got);
			answer_t want;
			answers_seen++;
			if (awaited_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result word %0d arrived with none expected: %s",
						answers_seen, show(got));
				return;
			end
			want = awaited_answers.pop_front();
			if (got.found !== want.found || got.position !== want.position ||
					got.first_seen !== want.first_seen ||
					got.multiplicity !== want.multiplicity ||
					got.class_count !== want.class_count ||
					got.items_seen !== want.items_seen || got.status !== want.status) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result word %0d mismatch, expected %s", answers_seen, show(want));
					$display("result word %0d mismatch, actual   %s", answers_seen, show(got));
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	skdc_cmd_if cmd_ch();
	skdc_res_if res_ch();

	dedup_scoreboard sb = new();

	int unsigned burst_left = 0;
	int unsigned sent_n = 0;
	int unsigned settings_n = 0;
	int unsigned holds_asked = 0;
	int unsigned holds_given = 0;
	logic [KEY_W-1:0] phase_keys[$];

	sorted_key_dedup_counter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.res       (res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#40_000_000;
		$display("sorted_key_dedup_counter_core_test: done, errors");
		$finish;
	end

	// Called at a rising edge. Leaves valid high so that a following word goes
	// out back to back; whoever pauses next lowers it.
	task automatic send_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 12);
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		burst_left--;
		cmd_ch.valid <= 1'b1;
		cmd_ch.op <= op;
		cmd_ch.key <= key;
		do @(posedge clk); while (!cmd_ch.ready);
		sb.take_command(op, key);
		sent_n++;
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The upper bits of the key width word are junk the block must ignore.
	task automatic program_regs(input logic [LIMIT_W-1:0] limit, input logic [KB_W-1:0] kb);
		logic [CFG_DATA_W-1:0] kb_word;
		kb_word = CFG_DATA_W'($urandom);
		kb_word[KB_W-1:0] = kb;
		cfg_we <= 1'b1;
		cfg_index <= CFG_ITEM_LIMIT;
		cfg_data <= limit;
		@(posedge clk);
		cfg_index <= CFG_KEY_BYTES;
		cfg_data <= kb_word;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(CFG_ITEM_LIMIT, limit);
		sb.write_reg(CFG_KEY_BYTES, kb_word);
		settings_n++;
	endtask

	// Keys in one pool share a random number of leading bytes.
	task automatic build_pool(input int unsigned n);
		logic [KEY_W-1:0] base;
		int unsigned j;
		base = {$urandom, $urandom};
		phase_keys.delete();
		for (j = 0; j < n; j++)
			phase_keys.push_back(base ^ ({$urandom, $urandom} >> (8 * $urandom_range(0, 7))));
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 4) == 0) return {$urandom, $urandom};
		return phase_keys[$urandom_range(0, phase_keys.size() - 1)];
	endfunction

	initial begin : answer_side
		logic [15:0] stall_mask;
		int unsigned seg_left, hold_left;
		logic rdy;
		answer_t got;
		res_ch.ready = 1'b0;
		stall_mask = '1;
		seg_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				got.found = res_ch.found;
				got.position = res_ch.position;
				got.first_seen = res_ch.first_seen;
				got.multiplicity = res_ch.multiplicity;
				got.class_count = res_ch.class_count;
				got.items_seen = res_ch.items_seen;
				got.status = res_ch.status;
				sb.check_answer(got);
			end
			if (hold_left != 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (holds_given != holds_asked) begin
				holds_given++;
				hold_left = LONG_HOLD - 1;
				rdy = 1'b0;
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(8, 80);
					stall_mask = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
				end
				seg_left--;
				stall_mask = {stall_mask[14:0], stall_mask[15]};
				rdy = stall_mask[0];
			end
			res_ch.ready <= rdy;
		end
	end

	initial begin : command_side
		logic [KEY_W-1:0] stored[$];
		logic [KEY_W-1:0] k;
		logic [LIMIT_W-1:0] limit;
		logic [KB_W-1:0] kb;
		int unsigned j, n, roll;
		cmd_ch.valid = 1'b0;
		cmd_ch.op = OP_INSERT;
		cmd_ch.key = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_ITEM_LIMIT;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset settings: empty table, both ends of
		// the key range, hits, misses, the spare op code and a clear.
		send_word(OP_LOOKUP, 64'h0);
		send_word(OP_INSERT, 64'h0);
		send_word(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
		send_word(OP_INSERT, 64'h8000_0000_0000_0000);
		send_word(OP_INSERT, 64'h0);
		send_word(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF);
		send_word(OP_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF);
		send_word(OP_SPARE, 64'h8000_0000_0000_0000);
		send_word(OP_SPARE, 64'h1);
		send_word(OP_INSERT, 64'h0123_4567_89AB_CDEF);
		send_word(OP_CLEAR, 64'h5A5A_A5A5_5A5A_A5A5);
		send_word(OP_LOOKUP, 64'h0);
		send_word(OP_INSERT, 64'hFEDC_BA98_7654_3210);

		// Width of zero acts as one byte, narrowed with an entry held; a limit
		// of two refuses the second insert sent here.
		settle();
		program_regs(9'd2, 4'd0);
		send_word(OP_INSERT, 64'hFE00_0000_0000_0000);
		send_word(OP_INSERT, 64'h1111_1111_1111_1111);
		send_word(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF);

		// Limit zero refuses everything; a width above eight acts as eight.
		settle();
		program_regs(9'd0, 4'd15);
		send_word(OP_INSERT, 64'hFEDC_BA98_7654_3210);

		// Limit above capacity, three-byte keys.
		settle();
		program_regs(9'd511, 4'd3);
		send_word(OP_CLEAR, 64'h0);
		send_word(OP_INSERT, 64'hAABB_CC00_0000_0001);
		send_word(OP_INSERT, 64'hAABB_CCFF_FFFF_FFFF);
		send_word(OP_INSERT, 64'hAABB_CBFF_FFFF_FFFF);
		send_word(OP_LOOKUP, 64'hAABB_CD00_0000_0000);

		// Fill the table to capacity. Partway through, the receiver holds off
		// long enough for the block to stall its input, and later the sender
		// waits for every outstanding word.
		settle();
		program_regs(9'd256, 4'd8);
		send_word(OP_CLEAR, 64'h0);
		for (j = 0; j < CAPACITY_DEF; j++) begin
			k = {$urandom, $urandom};
			stored.push_back(k);
			if (j == 100) holds_asked++;
			if (j == 180) drain();
			send_word(OP_INSERT, k);
		end
		for (j = 0; j < 8; j++) send_word(OP_INSERT, {$urandom, $urandom});
		for (j = 0; j < 24; j++) begin
			if (j % 2 == 0) send_word(OP_LOOKUP, stored[$urandom_range(0, stored.size() - 1)]);
			else send_word(($urandom_range(0, 3) == 0) ? OP_SPARE : OP_LOOKUP,
				{$urandom, $urandom});
		end

		// One key counted up to the table capacity, then refused.
		settle();
		program_regs(9'd300, 4'd2);
		send_word(OP_CLEAR, {$urandom, $urandom});
		for (j = 0; j < CAPACITY_DEF + 2; j++)
			send_word(OP_INSERT, {16'hBEEF, 16'($urandom), $urandom});
		send_word(OP_LOOKUP, 64'hBEEF_0000_0000_0000);

		// Random phases, each under its own settings; the table is kept
		// across most of them so that width changes hit a populated table.
		while (sent_n < ITEMS_TARGET) begin
			settle();
			case ($urandom_range(0, 5))
				0: limit = 9'd0;
				1: limit = LIMIT_W'($urandom_range(1, 40));
				2: limit = LIMIT_W'($urandom_range(41, 255));
				3: limit = 9'd256;
				4: limit = LIMIT_W'($urandom_range(257, 511));
				default: limit = 9'd255;
			endcase
			kb = ($urandom_range(0, 3) == 0) ? KB_W'($urandom_range(0, 15)) :
				KB_W'($urandom_range(1, 8));
			program_regs(limit, kb);
			build_pool($urandom_range(1, 64));
			if ($urandom_range(0, 2) == 0) send_word(OP_CLEAR, {$urandom, $urandom});
			n = $urandom_range(60, 200);
			for (j = 0; j < n; j++) begin
				roll = $urandom_range(0, 99);
				if (roll < 60) send_word(OP_INSERT, pick_key());
				else if (roll < 88) send_word(OP_LOOKUP, pick_key());
				else if (roll < 98) send_word(OP_SPARE, pick_key());
				else send_word(OP_CLEAR, {$urandom, $urandom});
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d command words under %0d register settings, %0d result words",
			sent_n, settings_n, sb.answers_seen);
		$display("hits %0d, refused inserts %0d, clears %0d, peak table %0d, peak count %0d",
			sb.hits, sb.refusals, sb.clears, sb.peak_distinct, sb.peak_mult);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("sorted_key_dedup_counter_core_test: done, clean");
		end else begin
			$display("sorted_key_dedup_counter_core_test: done, errors");
		end
		$finish;
	end

endmodule
